// ----- rtl/fba_pkg.sv -----
// Shared constants, types and command/status structs of the frame bitmap allocator.
package fba_pkg;

  localparam int NUM_FRAMES   = 4096;
  localparam int WORD_BITS    = 32;
  localparam int FRAME_W      = 12;
  localparam int FIELD_FRAMES = 4096;

  localparam int NUM_WORDS   = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int FRAME_LIMIT = (NUM_FRAMES < FIELD_FRAMES) ? NUM_FRAMES : FIELD_FRAMES;
  localparam int SCAN_WORDS  = (FRAME_LIMIT + WORD_BITS - 1) / WORD_BITS;
  localparam int TAIL_BITS   = FRAME_LIMIT - (SCAN_WORDS - 1) * WORD_BITS;
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int WORD_AW     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int SCAN_CW     = $clog2(SCAN_WORDS + 1);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [FRAME_W-1:0]   frame_t;
  typedef logic [WORD_AW-1:0]   waddr_t;

  // Bits of the last scanned word that lie beyond the frame limit read as used.
  localparam word_t TAIL_MASK = ~word_t'((65'(1) << TAIL_BITS) - 65'(1));

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_TEST  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_SKIP   = 2'd1,
    ST_NOFREE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    RES_ALLOC,
    RES_FULL,
    RES_SKIP,
    RES_FREE,
    RES_TEST
  } res_kind_e;

  typedef struct packed {
    logic      load;
    logic      rd;
    logic      rd_scan;
    logic      scan_inc;
    logic      wr_alloc;
    logic      wr_free;
    logic      res_set;
    res_kind_e res_kind;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  pf_zero;
    logic  pf_in_range;
    logic  word_full;
    logic  chk_last;
    logic  scan_ok;
  } st_t;

endpackage

// ----- rtl/fba_req_if.sv -----
// Request channel of the frame bitmap allocator.
interface fba_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic [fba_pkg::FRAME_W-1:0]  page_frame;
  logic                         kernel_page;
  logic                         write_req;

  modport source (output valid, mode, page_frame, kernel_page, write_req, input ready);
  modport sink   (input valid, mode, page_frame, kernel_page, write_req, output ready);
endinterface

// ----- rtl/fba_rsp_if.sv -----
// Response channel of the frame bitmap allocator.
interface fba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [fba_pkg::FRAME_W-1:0]  new_frame;
  logic                         present;
  logic                         writable;
  logic                         user_access;
  logic [1:0]                   status;
  logic                         frame_used;

  modport source (output valid, new_frame, present, writable, user_access, status,
                  frame_used, input ready);
  modport sink   (input valid, new_frame, present, writable, user_access, status,
                  frame_used, output ready);
endinterface

// ----- rtl/frame_bitmap_allocator.sv -----
// An allocate with a free page entry searches the bitmap from request transfer to result,
// one bitmap word (128 words) checked per cycle on the single memory read port.
// Free reads its word and then modify-writes it, test only reads it; skipped requests read nothing.
// One request is in work at a time; the next is taken while a result waits for its transfer.
// Reset clears the per-word valid bits at once, so every frame reads free; no clearing pass.
module frame_bitmap_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  fba_req_if.sink     req_i,
  fba_rsp_if.source   rsp_o
);

  fba_pkg::cmd_t cmd;
  fba_pkg::st_t  st;
  logic          out_valid;

  fba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  fba_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (req_i.mode),
    .page_frame_i  (req_i.page_frame),
    .kernel_page_i (req_i.kernel_page),
    .write_req_i   (req_i.write_req),
    .cmd_i         (cmd),
    .st_o          (st),
    .new_frame_o   (rsp_o.new_frame),
    .present_o     (rsp_o.present),
    .writable_o    (rsp_o.writable),
    .user_access_o (rsp_o.user_access),
    .status_o      (rsp_o.status),
    .frame_used_o  (rsp_o.frame_used)
  );

  assign rsp_o.valid = out_valid;

endmodule

// ----- rtl/fba_ctrl.sv -----
// Controller state machine: sequences decode, bitmap scan, read-modify-write and response.
module fba_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  fba_pkg::st_t    st_i,
  output fba_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FREE,
    S_TEST,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o          = '0;
    cmd_o.res_kind = fba_pkg::RES_SKIP;
    state_d        = state_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        unique case (st_i.mode)
          fba_pkg::MODE_ALLOC: begin
            if (st_i.pf_zero) begin
              cmd_o.rd       = 1'b1;
              cmd_o.rd_scan  = 1'b1;
              cmd_o.scan_inc = 1'b1;
              state_d        = S_SCAN;
            end else begin
              cmd_o.res_set = 1'b1;
              state_d       = S_RESP;
            end
          end
          fba_pkg::MODE_FREE: begin
            if (!st_i.pf_zero && st_i.pf_in_range) begin
              cmd_o.rd = 1'b1;
              state_d  = S_FREE;
            end else begin
              cmd_o.res_set = 1'b1;
              state_d       = S_RESP;
            end
          end
          fba_pkg::MODE_TEST: begin
            cmd_o.rd = 1'b1;
            state_d  = S_TEST;
          end
          fba_pkg::MODE_NOP: begin
            cmd_o.res_set = 1'b1;
            state_d       = S_RESP;
          end
        endcase
      end
      S_SCAN: begin
        if (!st_i.word_full) begin
          cmd_o.wr_alloc = 1'b1;
          cmd_o.res_set  = 1'b1;
          cmd_o.res_kind = fba_pkg::RES_ALLOC;
          state_d        = S_RESP;
        end else if (st_i.chk_last) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_kind = fba_pkg::RES_FULL;
          state_d        = S_RESP;
        end else begin
          // advance: check this word while the next one is read
          cmd_o.rd       = 1'b1;
          cmd_o.rd_scan  = 1'b1;
          cmd_o.scan_inc = 1'b1;
        end
      end
      S_FREE: begin
        cmd_o.wr_free  = 1'b1;
        cmd_o.res_set  = 1'b1;
        cmd_o.res_kind = fba_pkg::RES_FREE;
        state_d        = S_RESP;
      end
      S_TEST: begin
        cmd_o.res_set  = 1'b1;
        cmd_o.res_kind = fba_pkg::RES_TEST;
        state_d        = S_RESP;
      end
      S_RESP: begin
        // hold until the output register is free
        cmd_o.out_load = !out_valid_q || out_ready_i;
        if (cmd_o.out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load)   out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending transfer");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rd && cmd_o.rd_scan) |-> st_i.scan_ok)
    else $error("bitmap scan read past the last word");

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DECODE))
    else $error("accepted request not decoded");
`endif

endmodule

// ----- rtl/fba_dp.sv -----
// Datapath: request registers, used-frame bitmap memory, word search and result registers.
module fba_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [1:0]             mode_i,
  input  fba_pkg::frame_t        page_frame_i,
  input  logic                   kernel_page_i,
  input  logic                   write_req_i,
  input  fba_pkg::cmd_t          cmd_i,
  output fba_pkg::st_t           st_o,
  output fba_pkg::frame_t        new_frame_o,
  output logic                   present_o,
  output logic                   writable_o,
  output logic                   user_access_o,
  output logic [1:0]             status_o,
  output logic                   frame_used_o
);

  fba_pkg::mode_e  mode_q;
  fba_pkg::frame_t pf_q;
  logic            kern_q;
  logic            wr_q;

  logic [fba_pkg::SCAN_CW-1:0] scan_q;
  fba_pkg::waddr_t             chk_addr_q;
  fba_pkg::word_t              rdata_q;
  logic                        rvalid_q;

  fba_pkg::word_t              mem_q [fba_pkg::NUM_WORDS];
  logic [fba_pkg::NUM_WORDS-1:0] valid_q;

  fba_pkg::frame_t res_frame_q, res_frame_d;
  logic            res_pres_q, res_wr_q, res_usr_q, res_fu_q;
  logic            res_pres_d, res_wr_d, res_usr_d, res_fu_d;
  logic [1:0]      res_st_q, res_st_d;

  fba_pkg::frame_t out_frame_q;
  logic            out_pres_q, out_wr_q, out_usr_q, out_fu_q;
  logic [1:0]      out_st_q;

  fba_pkg::waddr_t          raddr;
  fba_pkg::waddr_t          pf_word;
  logic [fba_pkg::BIT_W-1:0] pf_bit;
  fba_pkg::word_t           word_rd;
  fba_pkg::word_t           word_eff;
  logic [fba_pkg::BIT_W-1:0] free_idx;
  logic                     pf_in_range;
  logic                     chk_last;
  fba_pkg::word_t           wdata;
  fba_pkg::frame_t          alloc_frame;

  assign pf_word     = fba_pkg::WORD_AW'(pf_q >> fba_pkg::BIT_W);
  assign pf_bit      = pf_q[fba_pkg::BIT_W-1:0];
  assign pf_in_range = (13'(pf_q) < 13'(fba_pkg::FRAME_LIMIT));
  assign chk_last    = (chk_addr_q == fba_pkg::WORD_AW'(fba_pkg::SCAN_WORDS - 1));
  assign raddr       = cmd_i.rd_scan ? fba_pkg::WORD_AW'(scan_q) : pf_word;

  // A word never written reads as all free.
  assign word_rd  = rvalid_q ? rdata_q : '0;
  assign word_eff = word_rd | (chk_last ? fba_pkg::TAIL_MASK : '0);

  always_comb begin
    free_idx = '0;
    for (int i = fba_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (!word_eff[i]) free_idx = fba_pkg::BIT_W'(i);
    end
  end

  assign alloc_frame = fba_pkg::FRAME_W'({chk_addr_q, free_idx});
  assign wdata = cmd_i.wr_alloc ? (word_rd | (fba_pkg::word_t'(1) << free_idx))
                                : (word_rd & ~(fba_pkg::word_t'(1) << pf_bit));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= fba_pkg::mode_e'(mode_i);
      pf_q   <= page_frame_i;
      kern_q <= kernel_page_i;
      wr_q   <= write_req_i;
    end
    if (cmd_i.load) scan_q <= '0;
    else if (cmd_i.scan_inc) scan_q <= scan_q + 1'b1;
    if (cmd_i.rd) begin
      chk_addr_q <= raddr;
      rdata_q    <= mem_q[raddr];
      rvalid_q   <= valid_q[raddr];
    end
    if (cmd_i.wr_alloc || cmd_i.wr_free) mem_q[chk_addr_q] <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.wr_alloc || cmd_i.wr_free) begin
      valid_q[chk_addr_q] <= 1'b1;
    end
  end

  always_comb begin
    res_frame_d = pf_q;
    res_pres_d  = 1'b0;
    res_wr_d    = 1'b0;
    res_usr_d   = 1'b0;
    res_fu_d    = 1'b0;
    res_st_d    = fba_pkg::ST_SKIP;
    case (cmd_i.res_kind)
      fba_pkg::RES_ALLOC: begin
        res_frame_d = alloc_frame;
        res_pres_d  = 1'b1;
        res_wr_d    = wr_q;
        res_usr_d   = !kern_q;
        res_st_d    = fba_pkg::ST_DONE;
      end
      fba_pkg::RES_FULL: begin
        res_frame_d = '0;
        res_st_d    = fba_pkg::ST_NOFREE;
      end
      fba_pkg::RES_FREE: begin
        res_frame_d = '0;
        res_st_d    = fba_pkg::ST_DONE;
      end
      fba_pkg::RES_TEST: begin
        res_fu_d = pf_in_range && word_rd[pf_bit];
        res_st_d = fba_pkg::ST_DONE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      res_frame_q <= res_frame_d;
      res_pres_q  <= res_pres_d;
      res_wr_q    <= res_wr_d;
      res_usr_q   <= res_usr_d;
      res_fu_q    <= res_fu_d;
      res_st_q    <= res_st_d;
    end
    if (cmd_i.out_load) begin
      out_frame_q <= res_frame_q;
      out_pres_q  <= res_pres_q;
      out_wr_q    <= res_wr_q;
      out_usr_q   <= res_usr_q;
      out_st_q    <= res_st_q;
      out_fu_q    <= res_fu_q;
    end
  end

  assign st_o.mode        = mode_q;
  assign st_o.pf_zero     = (pf_q == '0);
  assign st_o.pf_in_range = pf_in_range;
  assign st_o.word_full   = &word_eff;
  assign st_o.chk_last    = chk_last;
  assign st_o.scan_ok     = (scan_q < fba_pkg::SCAN_CW'(fba_pkg::SCAN_WORDS));

  assign new_frame_o   = out_frame_q;
  assign present_o     = out_pres_q;
  assign writable_o    = out_wr_q;
  assign user_access_o = out_usr_q;
  assign status_o      = out_st_q;
  assign frame_used_o  = out_fu_q;

endmodule
